[rtl/core/spectral_energy_onset_detector_core_defines.svh]
// Assertion macros for the spectral energy onset detector checker.
// Plain header, no dependencies; the checker module includes it.
`ifndef SPECTRAL_ENERGY_ONSET_DETECTOR_CORE_DEFINES_SVH
`define SPECTRAL_ENERGY_ONSET_DETECTOR_CORE_DEFINES_SVH

// clocked property, ignored while reset is held
`define SED_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked property, also checked through reset
`define SED_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[rtl/core/sed_pkg.sv]
// Shared types and constants of the spectral energy onset detector.
// No dependencies.
`default_nettype none
package sed_pkg;

  localparam int unsigned MAX_BINS    = 128;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned FILL_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned DIV_STEPS   = 42;
  localparam int unsigned SQRT_STEPS  = 21;

  typedef enum logic [2:0] {
    CFG_BIN_LIMIT = 3'd0,
    CFG_CLIP      = 3'd1,
    CFG_PERIOD    = 3'd2,
    CFG_WIN_MAX   = 3'd3,
    CFG_WIN_KEEP  = 3'd4,
    CFG_RATIO     = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0]  bin_limit;
    logic [14:0] clip;
    logic [15:0] period;
    logic [15:0] win_max;
    logic [15:0] win_keep;
    logic [15:0] ratio;
  } cfg_t;

  // one finished frame, handed from front to back
  typedef struct packed {
    logic [39:0] sq_sum;
    logic [39:0] low_sum;
    logic        low_valid;
    logic [8:0]  n_bins;
    logic [14:0] peak;
    logic [7:0]  peak_bin;
    logic [31:0] time_ms;
  } frame_rec_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SQRT,
    ST_WIN_TRIM,
    ST_WIN_ADD,
    ST_AVG_DIV,
    ST_MUL,
    ST_EMIT
  } back_state_e;

endpackage
`default_nettype wire

[rtl/core/sed_front.sv]
// Front end: takes bins, clips, tracks peak and sums of squares per frame.
// Depends on sed_pkg.
`default_nettype none
module sed_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire sed_pkg::cfg_t     cfg_i,
  input  wire logic              accept_i,
  input  wire logic [15:0]       magnitude_i,
  input  wire logic              frame_end_i,
  input  wire logic [31:0]       time_ms_i,
  output sed_pkg::frame_rec_t    rec_o,
  output logic                   push_o
);
  import sed_pkg::*;

  logic [7:0]  idx_q, idx_d;
  logic [39:0] sum_q, sum_d, low_q, low_d;
  logic [14:0] peak_q, peak_d;
  logic [7:0]  pbin_q, pbin_d;

  logic [16:0] abs_v;
  logic        clipped;
  logic [15:0] a;
  logic [31:0] sq;
  logic        last;
  logic [39:0] sum_n, low_n;
  logic [14:0] peak_n;
  logic [7:0]  pbin_n;

  always_comb begin
    abs_v   = magnitude_i[15] ? (17'd0 - {magnitude_i[15], magnitude_i})
                              : {1'b0, magnitude_i};
    clipped = abs_v > {2'b00, cfg_i.clip};
    a       = clipped ? 16'd0 : abs_v[15:0];
    sq      = a * a;
    sum_n   = sum_q + {8'd0, sq};
    low_n   = (idx_q <= cfg_i.bin_limit) ? low_q + {8'd0, sq} : low_q;
    peak_n  = peak_q;
    pbin_n  = pbin_q;
    if (!magnitude_i[15] && !clipped && (a[14:0] > peak_q)) begin
      peak_n = a[14:0];
      pbin_n = idx_q;
    end
    last    = frame_end_i || (idx_q == 8'(MAX_BINS - 1));

    rec_o.sq_sum    = sum_n;
    rec_o.low_sum   = low_n;
    rec_o.low_valid = idx_q > cfg_i.bin_limit;
    rec_o.n_bins    = {1'b0, idx_q} + 9'd1;
    rec_o.peak      = peak_n;
    rec_o.peak_bin  = pbin_n;
    rec_o.time_ms   = time_ms_i;
    push_o          = accept_i && last;

    idx_d  = idx_q;
    sum_d  = sum_q;
    low_d  = low_q;
    peak_d = peak_q;
    pbin_d = pbin_q;
    if (accept_i) begin
      if (last) begin
        idx_d  = '0;
        sum_d  = '0;
        low_d  = '0;
        peak_d = '0;
        pbin_d = '0;
      end else begin
        idx_d  = idx_q + 8'd1;
        sum_d  = sum_n;
        low_d  = low_n;
        peak_d = peak_n;
        pbin_d = pbin_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      sum_q  <= '0;
      low_q  <= '0;
      peak_q <= '0;
      pbin_q <= '0;
    end else begin
      idx_q  <= idx_d;
      sum_q  <= sum_d;
      low_q  <= low_d;
      peak_q <= peak_d;
      pbin_q <= pbin_d;
    end
  end

endmodule
`default_nettype wire

[rtl/core/sed_fifo.sv]
// Two-entry queue of finished frames between front and back.
// Depends on sed_pkg.
`default_nettype none
module sed_fifo (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire sed_pkg::frame_rec_t wdata_i,
  output logic                     full_o,
  output logic                     valid_o,
  input  wire logic                pop_i,
  output sed_pkg::frame_rec_t      rdata_o
);
  import sed_pkg::*;

  frame_rec_t  mem_q [2];
  logic        wp_q, wp_d, rp_q, rp_d;
  logic [1:0]  cnt_q, cnt_d;

  always_comb begin
    full_o  = cnt_q == 2'd2;
    valid_o = cnt_q != 2'd0;
    rdata_o = mem_q[rp_q];
    wp_d    = push_i ? ~wp_q : wp_q;
    rp_d    = pop_i ? ~rp_q : rp_q;
    cnt_d   = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

[rtl/core/sed_back.sv]
// Back end: per-frame RMS (shared divider and square root), window update,
// average and onset decision, output register. Depends on sed_pkg.
`default_nettype none
module sed_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire sed_pkg::cfg_t       cfg_i,
  input  wire logic                job_valid_i,
  input  wire sed_pkg::frame_rec_t job_i,
  output logic                     job_pop_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [71:0]              out_data_o
);
  import sed_pkg::*;

  back_state_e state_q, state_d;
  frame_rec_t  job_q;
  logic        phase_q;
  logic [5:0]  cnt_q;

  // shared restoring divider
  logic [41:0] dq_q;
  logic [15:0] drem_q, ddiv_q;
  logic [16:0] drem_sh;
  logic [15:0] drem_n;
  logic [41:0] dq_n;
  // shared digit-by-digit square root
  logic [41:0] sx_q;
  logic [21:0] srem_q;
  logic [20:0] sroot_q;
  logic [23:0] srem_sh, strial;
  logic [21:0] srem_n;
  logic [20:0] sroot_n;
  logic [15:0] sroot_sat;

  logic [15:0] level_q, inst_q, avg_q;
  logic [31:0] prod_q;
  logic        out_valid_q;
  logic [71:0] out_q;

  // window state
  logic                 started_q;
  logic [31:0]          wstart_q, lchunk_q;
  logic [31:0]          chunk_e_q, win_e_q;
  logic [15:0]          chunk_c_q, win_c_q;
  logic [31:0]          qe_q [QUEUE_DEPTH];
  logic [15:0]          qc_q [QUEUE_DEPTH];
  logic [FILL_W-1:0]    fill_q;

  logic [31:0]          now, start_e, last_e;
  logic                 push, push_ok, trim, do_sub;
  logic [FILL_W-1:0]    fill_a, fill_n;
  logic [31:0]          qe_n [QUEUE_DEPTH];
  logic [15:0]          qc_n [QUEUE_DEPTH];
  logic [31:0]          win_e_sub, win_e_add, chunk_e_add;
  logic [15:0]          win_c_sub, win_c_add, chunk_c_add;
  logic [32:0]          we_sum, ce_sum;

  logic        div_last, sqrt_last, can_emit;

  // datapath steps
  always_comb begin
    drem_sh = {drem_q, dq_q[41]};
    if (drem_sh >= {1'b0, ddiv_q}) begin
      drem_n = 16'(drem_sh - {1'b0, ddiv_q});
      dq_n   = {dq_q[40:0], 1'b1};
    end else begin
      drem_n = drem_sh[15:0];
      dq_n   = {dq_q[40:0], 1'b0};
    end
    srem_sh = {srem_q, sx_q[41:40]};
    strial  = {1'b0, sroot_q, 2'b01};
    if (srem_sh >= strial) begin
      srem_n  = 22'(srem_sh - strial);
      sroot_n = {sroot_q[19:0], 1'b1};
    end else begin
      srem_n  = srem_sh[21:0];
      sroot_n = {sroot_q[19:0], 1'b0};
    end
    sroot_sat = (sroot_n[20:16] != 5'd0) ? 16'hFFFF : sroot_n[15:0];
    div_last  = cnt_q == 6'(DIV_STEPS - 1);
    sqrt_last = cnt_q == 6'(SQRT_STEPS - 1);
    can_emit  = !out_valid_q || out_ready_i;
  end

  // window: chunk push then trim
  always_comb begin
    now     = job_q.time_ms;
    start_e = started_q ? wstart_q : now;
    last_e  = started_q ? lchunk_q : now;
    push    = (now - last_e) >= {16'd0, cfg_i.period};
    push_ok = push && (fill_q < FILL_W'(QUEUE_DEPTH));
    fill_a  = push_ok ? fill_q + FILL_W'(1) : fill_q;
    trim    = (now - start_e) >= {16'd0, cfg_i.win_max};
    do_sub  = trim && (fill_a != '0);
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      qe_n[i] = qe_q[i];
      qc_n[i] = qc_q[i];
      if (push_ok && (fill_q == FILL_W'(i))) begin
        qe_n[i] = chunk_e_q;
        qc_n[i] = chunk_c_q;
      end
    end
    win_e_sub = (win_e_q > qe_n[0]) ? win_e_q - qe_n[0] : 32'd0;
    win_c_sub = (win_c_q > qc_n[0]) ? win_c_q - qc_n[0] : 16'd0;
    if (do_sub) begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
        qe_n[i] = qe_n[i + 1];
        qc_n[i] = qc_n[i + 1];
      end
    end
    fill_n = do_sub ? fill_a - FILL_W'(1) : fill_a;

    we_sum      = {1'b0, win_e_q} + {17'd0, inst_q};
    ce_sum      = {1'b0, chunk_e_q} + {17'd0, inst_q};
    win_e_add   = we_sum[32] ? 32'hFFFF_FFFF : we_sum[31:0];
    chunk_e_add = ce_sum[32] ? 32'hFFFF_FFFF : ce_sum[31:0];
    win_c_add   = (win_c_q == 16'hFFFF) ? win_c_q : win_c_q + 16'd1;
    chunk_c_add = (chunk_c_q == 16'hFFFF) ? chunk_c_q : chunk_c_q + 16'd1;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (job_valid_i) state_d = ST_DIV;
      ST_DIV:      if (div_last) state_d = ST_SQRT;
      ST_SQRT: begin
        if (sqrt_last) begin
          state_d = (!phase_q && job_q.low_valid) ? ST_DIV : ST_WIN_TRIM;
        end
      end
      ST_WIN_TRIM: state_d = ST_WIN_ADD;
      ST_WIN_ADD:  state_d = (win_c_add == 16'd0) ? ST_MUL : ST_AVG_DIV;
      ST_AVG_DIV:  if (div_last) state_d = ST_MUL;
      ST_MUL:      state_d = ST_EMIT;
      ST_EMIT:     if (can_emit) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    job_pop_o   = (state_q == ST_IDLE) && job_valid_i;
    out_valid_o = out_valid_q;
    out_data_o  = out_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      started_q   <= 1'b0;
      wstart_q    <= '0;
      lchunk_q    <= '0;
      chunk_e_q   <= '0;
      chunk_c_q   <= '0;
      win_e_q     <= '0;
      win_c_q     <= '0;
      fill_q      <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_EMIT && can_emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == ST_WIN_TRIM) begin
        started_q <= 1'b1;
        wstart_q  <= trim ? now - {16'd0, cfg_i.win_keep} : start_e;
        lchunk_q  <= push ? now : last_e;
        if (push) begin
          chunk_e_q <= '0;
          chunk_c_q <= '0;
        end
        if (do_sub) begin
          win_e_q <= win_e_sub;
          win_c_q <= win_c_sub;
        end
        fill_q <= fill_n;
      end
      if (state_q == ST_WIN_ADD) begin
        chunk_e_q <= chunk_e_add;
        chunk_c_q <= chunk_c_add;
        win_e_q   <= win_e_add;
        win_c_q   <= win_c_add;
      end
    end
  end

  // payload and working registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        job_q   <= job_i;
        phase_q <= 1'b0;
        dq_q    <= {job_i.sq_sum, 2'b00};
        drem_q  <= '0;
        ddiv_q  <= {7'd0, job_i.n_bins};
        cnt_q   <= '0;
      end
      ST_DIV: begin
        dq_q   <= dq_n;
        drem_q <= drem_n;
        if (div_last) begin
          sx_q    <= dq_n;
          srem_q  <= '0;
          sroot_q <= '0;
          cnt_q   <= '0;
        end else begin
          cnt_q <= cnt_q + 6'd1;
        end
      end
      ST_SQRT: begin
        sx_q    <= {sx_q[39:0], 2'b00};
        srem_q  <= srem_n;
        sroot_q <= sroot_n;
        if (sqrt_last && !phase_q) begin
          cnt_q <= '0;
        end else begin
          cnt_q <= cnt_q + 6'd1;
        end
        if (sqrt_last) begin
          if (phase_q) begin
            inst_q <= sroot_sat;
          end else begin
            level_q <= sroot_sat;
            inst_q  <= '0;
            phase_q <= 1'b1;
            dq_q    <= {job_q.low_sum, 2'b00};
            drem_q  <= '0;
            ddiv_q  <= {8'd0, cfg_i.bin_limit} + 16'd1;
          end
        end
      end
      ST_WIN_TRIM: begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
          qe_q[i] <= qe_n[i];
          qc_q[i] <= qc_n[i];
        end
      end
      ST_WIN_ADD: begin
        dq_q   <= {10'd0, win_e_add};
        drem_q <= '0;
        ddiv_q <= win_c_add;
        cnt_q  <= '0;
        avg_q  <= '0;
      end
      ST_AVG_DIV: begin
        dq_q   <= dq_n;
        drem_q <= drem_n;
        cnt_q  <= cnt_q + 6'd1;
        if (div_last) begin
          avg_q <= (dq_n[41:16] != '0) ? 16'hFFFF : dq_n[15:0];
        end
      end
      ST_MUL: begin
        prod_q <= cfg_i.ratio * inst_q;
      end
      ST_EMIT: begin
        if (can_emit) begin
          out_q <= {(prod_q > {avg_q, 16'd0}), avg_q, inst_q,
                    job_q.peak_bin, job_q.peak, level_q};
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

[rtl/core/spectral_energy_onset_detector_core.sv]
// Top level of the spectral energy onset detector: config registers,
// front end, frame queue and back end. Depends on sed_pkg and submodules.
//
//  channel   | direction | handshake            | payload
//  ----------+-----------+----------------------+--------------------------------
//  s_axis    | in        | tvalid/tready        | tdata magnitude,time_ms; tlast
//  m_axis    | out       | tvalid/tready        | tdata one result item per frame
//  cfg       | in        | cfg_we_i, no wait    | cfg_idx_i, cfg_data_i
//
// Bins are taken one per cycle; s_axis_tready drops only when both frame
// queue entries are occupied. The back end works through each frame in steps
// (two 42-step divisions and two 21-step roots for the RMS values, one of
// each when the low band is never closed, a 42-step division for the
// window average, plus control states), so frames that arrive faster than
// that stall the input once the queue fills. Reset is asynchronous, active
// low, and clears control and window state at once, but not the chunk entries.
// A result waits in the output register without blocking the back end's
// next frame until it reaches the emit step.
`default_nettype none
module spectral_energy_onset_detector_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,   // [15:0] magnitude, [47:16] time_ms
  input  wire logic        s_axis_tlast,   // frame_end
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [15:0] sound_level, [30:16] peak_value, [38:31] peak_bin,
  // [54:39] instant_energy, [70:55] average_energy, [71] onset
  output logic [71:0]      m_axis_tdata,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i
);
  import sed_pkg::*;

  cfg_t       cfg_q;
  frame_rec_t rec_w, job_w;
  logic       accept, push, full, job_valid, job_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bin_limit <= 8'd6;
      cfg_q.clip      <= 15'd20480;
      cfg_q.period    <= 16'd500;
      cfg_q.win_max   <= 16'd1250;
      cfg_q.win_keep  <= 16'd750;
      cfg_q.ratio     <= 16'd42598;   // about 0.65 in Q0.16
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BIN_LIMIT: cfg_q.bin_limit <= cfg_data_i[7:0];
        CFG_CLIP:      cfg_q.clip      <= cfg_data_i[14:0];
        CFG_PERIOD:    cfg_q.period    <= cfg_data_i;
        CFG_WIN_MAX:   cfg_q.win_max   <= cfg_data_i;
        CFG_WIN_KEEP:  cfg_q.win_keep  <= cfg_data_i;
        CFG_RATIO:     cfg_q.ratio     <= cfg_data_i;
        default: ;     // indexes past the list are ignored
      endcase
    end
  end

  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && !full;

  sed_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .accept_i    (accept),
    .magnitude_i (s_axis_tdata[15:0]),
    .frame_end_i (s_axis_tlast),
    .time_ms_i   (s_axis_tdata[47:16]),
    .rec_o       (rec_w),
    .push_o      (push)
  );

  sed_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (rec_w),
    .full_o  (full),
    .valid_o (job_valid),
    .pop_i   (job_pop),
    .rdata_o (job_w)
  );

  sed_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (job_valid),
    .job_i       (job_w),
    .job_pop_o   (job_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule
`default_nettype wire

[rtl/core/sed_checker.sv]
// Port-level checks on the onset detector, bound to the top level.
// Depends on spectral_energy_onset_detector_core_defines.svh.
`default_nettype none
`include "spectral_energy_onset_detector_core_defines.svh"
module sed_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [47:0] s_axis_tdata,
  input wire logic        s_axis_tlast,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [71:0] m_axis_tdata,
  input wire logic        cfg_we_i,
  input wire logic [2:0]  cfg_idx_i,
  input wire logic [15:0] cfg_data_i
);

  `SED_ASSERT_RST(a_rst_idle, !rst_ni |=> !m_axis_tvalid, "result item during reset")
  `SED_ASSERT(a_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled item changed")
  `SED_ASSERT(a_peak_bin, m_axis_tvalid && (m_axis_tdata[30:16] == 15'd0) |-> m_axis_tdata[38:31] == 8'd0, "peak index without peak")
  `SED_ASSERT(a_onset, m_axis_tvalid && m_axis_tdata[71] |-> m_axis_tdata[54:39] != 16'd0, "onset with zero instant energy")

endmodule

bind spectral_energy_onset_detector_core sed_checker u_sed_checker (.*);
`default_nettype wire
